@@ design/ffa_pkg.sv @@
// package for the first-fit block allocator
// sizes, segment entry layout, memory request bundle and controller states
// no dependencies
package ffa_pkg;

	localparam int ARENA_BYTES  = 4096;
	localparam int HEADER_BYTES = 24;
	localparam int MAX_SEGMENTS = 64;

	localparam int OFF_W  = 12;
	localparam int SLOT_W = $clog2(MAX_SEGMENTS);
	localparam int POS_W  = $clog2(ARENA_BYTES + HEADER_BYTES + (1 << OFF_W));

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_SPACE   = 2'd1;
	localparam logic [1:0] ST_BAD_OFFSET = 2'd2;

	localparam logic ACT_ALLOC = 1'b0;

	typedef struct packed {
		logic [POS_W-1:0]  start;
		logic [POS_W-1:0]  size;
		logic              free;
		logic              has_next;
		logic [SLOT_W-1:0] next;
	} seg_entry_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		seg_entry_t        wdata;
		logic [SLOT_W-1:0] raddr;
	} seg_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK,
		S_SCAN,
		S_SPLIT_NEW,
		S_SPLIT_OLD,
		S_C_START,
		S_C_FIRST,
		S_C_NEXT,
		S_DONE
	} ctrl_state_t;

	localparam seg_entry_t ENTRY0_RESET = '{
		start:    '0,
		size:     POS_W'(ARENA_BYTES - HEADER_BYTES),
		free:     1'b1,
		has_next: 1'b0,
		next:     '0
	};

endpackage

@@ design/ffa_seg_ram.sv @@
// segment table memory: one write port, one read port, registered read data
// depends on ffa_pkg
module ffa_seg_ram (
	input  logic              clk,
	input  ffa_pkg::seg_req_t req,
	output ffa_pkg::seg_entry_t rdata
);
	import ffa_pkg::*;

	seg_entry_t mem [MAX_SEGMENTS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

@@ design/ffa_ctrl.sv @@
// allocator sequencer: chain walk, free slot scan, split, free and merge pass
// depends on ffa_pkg, drives ffa_seg_ram through a seg_req_t bundle
module ffa_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      in_action,
	input  logic [ffa_pkg::OFF_W-1:0] in_request,
	input  logic [ffa_pkg::OFF_W-1:0] in_release,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                out_status,
	output logic [ffa_pkg::OFF_W-1:0] out_offset,
	output ffa_pkg::seg_req_t         req,
	input  ffa_pkg::seg_entry_t       ram_rdata
);
	import ffa_pkg::*;

	ctrl_state_t       state_q, state_d;
	logic [SLOT_W-1:0] cur_q, scan_q, slot_s_q;
	seg_entry_t        b_q;
	logic              act_q;
	logic [OFF_W-1:0]  n_q, p_q;
	logic [1:0]        res_status_q;
	logic [OFF_W-1:0]  res_off_q;
	logic [MAX_SEGMENTS-1:0] in_use_q;
	logic              init0_q, rd0_q;
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [OFF_W-1:0]  out_off_q;

	seg_entry_t       rdat, merged;
	logic [POS_W-1:0] split_sz, pay_off;
	logic             can_split, can_whole, hit, load_out;

	assign rdat      = (rd0_q && !init0_q) ? ENTRY0_RESET : ram_rdata;
	assign split_sz  = POS_W'(n_q) + POS_W'(HEADER_BYTES);
	assign can_split = rdat.free && (rdat.size > split_sz);
	assign can_whole = rdat.free && (rdat.size >= POS_W'(n_q));
	assign pay_off   = rdat.start + POS_W'(HEADER_BYTES);
	assign hit       = (pay_off == POS_W'(p_q));
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		merged          = b_q;
		merged.size     = b_q.size + rdat.size + POS_W'(HEADER_BYTES);
		merged.has_next = rdat.has_next;
		merged.next     = rdat.next;
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_offset = out_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.we    = 1'b0;
		req.waddr = cur_q;
		req.wdata = rdat;
		req.raddr = rdat.next;
		unique case (state_q)
			S_IDLE: begin
				req.raddr = '0;
				if (in_valid) state_d = S_WALK;
			end
			S_WALK: begin
				if (act_q == ACT_ALLOC) begin
					if (can_split) begin
						state_d = S_SCAN;
					end else if (can_whole) begin
						req.we         = 1'b1;
						req.wdata.free = 1'b0;
						state_d        = S_DONE;
					end else if (!rdat.has_next) begin
						state_d = S_DONE;
					end
				end else begin
					if (hit) begin
						req.we         = 1'b1;
						req.wdata.free = 1'b1;
						state_d        = S_C_START;
					end else if (!rdat.has_next) begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (!in_use_q[scan_q]) begin
					state_d = S_SPLIT_NEW;
				end else if (scan_q == SLOT_W'(MAX_SEGMENTS - 1)) begin
					req.we         = 1'b1;
					req.wdata      = b_q;
					req.wdata.free = 1'b0;
					state_d        = S_DONE;
				end
			end
			S_SPLIT_NEW: begin
				req.we             = 1'b1;
				req.waddr          = slot_s_q;
				req.wdata.start    = b_q.start + split_sz;
				req.wdata.size     = b_q.size - split_sz;
				req.wdata.free     = 1'b1;
				req.wdata.has_next = b_q.has_next;
				req.wdata.next     = b_q.next;
				state_d            = S_SPLIT_OLD;
			end
			S_SPLIT_OLD: begin
				req.we             = 1'b1;
				req.wdata.start    = b_q.start;
				req.wdata.size     = POS_W'(n_q);
				req.wdata.free     = 1'b0;
				req.wdata.has_next = 1'b1;
				req.wdata.next     = slot_s_q;
				state_d            = S_DONE;
			end
			S_C_START: begin
				req.raddr = '0;
				state_d   = S_C_FIRST;
			end
			S_C_FIRST: begin
				state_d = rdat.has_next ? S_C_NEXT : S_DONE;
			end
			S_C_NEXT: begin
				if (b_q.free && rdat.free) begin
					req.we    = 1'b1;
					req.wdata = merged;
				end
				if (!rdat.has_next) state_d = S_DONE;
			end
			S_DONE: begin
				if (load_out) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q    <= MAX_SEGMENTS'(1);
			init0_q     <= 1'b0;
			rd0_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd0_q <= (req.raddr == '0);
			if (req.we && req.waddr == '0) init0_q <= 1'b1;
			if (state_q == S_SPLIT_NEW) in_use_q[slot_s_q] <= 1'b1;
			if (state_q == S_C_NEXT && b_q.free && rdat.free) in_use_q[b_q.next] <= 1'b0;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= res_status_q;
			out_off_q    <= res_off_q;
		end
		unique case (state_q)
			S_IDLE: begin
				act_q <= in_action;
				n_q   <= in_request;
				p_q   <= in_release;
				cur_q <= '0;
			end
			S_WALK: begin
				b_q          <= rdat;
				scan_q       <= '0;
				cur_q        <= rdat.next;
				res_status_q <= (act_q == ACT_ALLOC) ? ST_NO_SPACE : ST_BAD_OFFSET;
				res_off_q    <= '0;
				if (act_q == ACT_ALLOC) begin
					if (can_split) begin
						cur_q <= cur_q;
					end else if (can_whole) begin
						res_status_q <= ST_OK;
						res_off_q    <= pay_off[OFF_W-1:0];
					end
				end else if (hit) begin
					res_status_q <= ST_OK;
				end
			end
			S_SCAN: begin
				slot_s_q     <= scan_q;
				scan_q       <= scan_q + SLOT_W'(1);
				res_status_q <= ST_OK;
				res_off_q    <= OFF_W'(b_q.start + POS_W'(HEADER_BYTES));
			end
			S_C_START: begin
				cur_q <= '0;
			end
			S_C_FIRST: begin
				b_q <= rdat;
			end
			S_C_NEXT: begin
				if (b_q.free && rdat.free) begin
					b_q <= merged;
				end else begin
					cur_q <= b_q.next;
					b_q   <= rdat;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ design/first_fit_block_allocator_unit.sv @@
// channel   dir  signals                     contents
// request   in   s_tvalid s_tready s_tdata   tuser action, tdata request/release
// result    out  m_tvalid m_tready m_tdata   tdata status, payload offset
//
// one item at a time; an alloc walks the chain, and on a split also scans up to
// 64 slots for a free one and writes two entries; a free walks the chain to
// its block and then makes a merge pass over the whole chain
// the segment table memory (one read, one write port) paces the walk, one entry per cycle
// reset clears control state; slot 0 reads as the whole free arena until written
// the result register holds while m_tready is low; s_tready is high only when idle
// depends on ffa_pkg, ffa_ctrl, ffa_seg_ram
module first_fit_block_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // request_bytes[11:0], release_offset[23:12]
	input  logic        s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // status[1:0], payload_offset[13:2], zero[15:14]
);
	import ffa_pkg::*;

	seg_req_t         req;
	seg_entry_t       ram_rdata;
	logic [1:0]       status;
	logic [OFF_W-1:0] offset;

	ffa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_action  (s_tuser),
		.in_request (s_tdata[11:0]),
		.in_release (s_tdata[23:12]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (status),
		.out_offset (offset),
		.req        (req),
		.ram_rdata  (ram_rdata)
	);

	ffa_seg_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (ram_rdata)
	);

	assign m_tdata = {2'b00, offset, status};

endmodule

@@ design/ffa_checker.sv @@
// port-level checks for the allocator top level, with its bind
// depends on ffa_pkg and the first_fit_block_allocator_unit ports
module ffa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	import ffa_pkg::*;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] <= ST_BAD_OFFSET)
		else $error("undefined status");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[13:2] == 12'd0)
		else $error("offset on failed item");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped under stall");

endmodule

bind first_fit_block_allocator_unit ffa_checker u_ffa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ tb/sv/first_fit_block_allocator_unit_test.sv @@
// self-checking testbench for the first-fit block allocator unit
// directed table then random alloc/free traffic, checked against a local allocator model
// depends on ffa_pkg and first_fit_block_allocator_unit
module first_fit_block_allocator_unit_test;
	import ffa_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int N_RANDOM    = 1500;

	typedef struct {
		int unsigned start;
		int unsigned size;
		bit          free;
		bit          has_next;
		int unsigned next;
	} block_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] offset;
	} alloc_result_t;

	typedef struct {
		logic        act;
		logic [11:0] req;
		logic [11:0] rel;
		bit          known;
		logic [1:0]  status;
		logic [11:0] offset;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	block_t        blocks[MAX_SEGMENTS];
	bit            slot_busy[MAX_SEGMENTS];
	alloc_result_t pending_results[$];
	int unsigned   live_offsets[$];
	int            errors;
	int            cycles;
	bit            quiet_in;
	bit            quiet_out;

	first_fit_block_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void arena_reset();
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			blocks[i] = '{0, 0, 0, 0, 0};
			slot_busy[i] = 0;
		end
		blocks[0].size = ARENA_BYTES - HEADER_BYTES;
		blocks[0].free = 1;
		slot_busy[0] = 1;
	endfunction

	function automatic void merge_free_runs();
		int unsigned cur;
		int unsigned nx;
		cur = 0;
		for (int g = 0; g < 2 * MAX_SEGMENTS; g++) begin
			if (!blocks[cur].has_next || blocks[cur].next >= MAX_SEGMENTS)
				return;
			nx = blocks[cur].next;
			if (blocks[cur].free && blocks[nx].free) begin
				blocks[cur].size += blocks[nx].size + HEADER_BYTES;
				blocks[cur].has_next = blocks[nx].has_next;
				blocks[cur].next = blocks[nx].next;
				blocks[nx] = '{0, 0, 0, 0, 0};
				slot_busy[nx] = 0;
			end else begin
				cur = nx;
			end
		end
	endfunction

	function automatic alloc_result_t allocate(int unsigned n);
		int unsigned cur;
		int unsigned split_at;
		int s;
		alloc_result_t r;
		cur = 0;
		split_at = n + HEADER_BYTES;
		r = '{ST_NO_SPACE, 12'd0};
		for (int g = 0; g < MAX_SEGMENTS; g++) begin
			if (blocks[cur].free && blocks[cur].size >= n) begin
				if (blocks[cur].size > split_at) begin
					s = -1;
					for (int i = MAX_SEGMENTS - 1; i >= 0; i--)
						if (!slot_busy[i])
							s = i;
					if (s >= 0) begin
						blocks[s].start = blocks[cur].start + split_at;
						blocks[s].size = blocks[cur].size - split_at;
						blocks[s].free = 1;
						blocks[s].has_next = blocks[cur].has_next;
						blocks[s].next = blocks[cur].next;
						slot_busy[s] = 1;
						blocks[cur].size = n;
						blocks[cur].has_next = 1;
						blocks[cur].next = s;
					end
				end
				blocks[cur].free = 0;
				r.status = ST_OK;
				r.offset = 12'(blocks[cur].start + HEADER_BYTES);
				return r;
			end
			if (!blocks[cur].has_next || blocks[cur].next >= MAX_SEGMENTS)
				break;
			cur = blocks[cur].next;
		end
		return r;
	endfunction

	function automatic alloc_result_t release_block(int unsigned p);
		int unsigned cur;
		cur = 0;
		for (int g = 0; g < MAX_SEGMENTS; g++) begin
			if (blocks[cur].start + HEADER_BYTES == p) begin
				blocks[cur].free = 1;
				merge_free_runs();
				return '{ST_OK, 12'd0};
			end
			if (!blocks[cur].has_next || blocks[cur].next >= MAX_SEGMENTS)
				break;
			cur = blocks[cur].next;
		end
		return '{ST_BAD_OFFSET, 12'd0};
	endfunction

	task automatic send_item(input logic act, input logic [11:0] req, input logic [11:0] rel,
			input bit known, input logic [1:0] st, input logic [11:0] off);
		alloc_result_t r;
		while (!quiet_in && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {rel, req};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (act == ACT_ALLOC) begin
			r = allocate(req);
			if (r.status == ST_OK)
				live_offsets.push_back(r.offset);
		end else begin
			r = release_block(rel);
		end
		if (known && (r.status !== st || r.offset !== off)) begin
			$display("%0t table row: expected %0d/%0d, model %0d/%0d", $time, st, off,
				r.status, r.offset);
			errors++;
		end
		pending_results.push_back(r);
	endtask

	always @(posedge clk) begin
		alloc_result_t exp_r;
		if (arst_n) begin
			cycles <= cycles + 1;
			m_tready <= quiet_out || ($urandom_range(99) >= 31);
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$display("%0t unexpected result: actual %h", $time, m_tdata);
					errors++;
				end else begin
					exp_r = pending_results.pop_front();
					if (m_tdata[1:0] !== exp_r.status || m_tdata[13:2] !== exp_r.offset ||
							m_tdata[15:14] !== 2'b00) begin
						$display("%0t mismatch: expected status %0d offset %0d, actual %0d %0d",
							$time, exp_r.status, exp_r.offset, m_tdata[1:0], m_tdata[13:2]);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk)
		if (cycles >= CYCLE_LIMIT) begin
			$display("first_fit_block_allocator_unit_test failed");
			$finish;
		end

	initial begin
		stim_row_t rows[$];
		int unsigned pick;
		int drain;
		logic [11:0] rel;
		logic [11:0] req;
		errors = 0;
		cycles = 0;
		quiet_in = 0;
		quiet_out = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		arena_reset();
		// after reset, extremes, errors, split, whole take, merge
		rows.push_back('{ACT_ALLOC, 12'd0, 12'd0, 1, ST_OK, 12'd24});
		rows.push_back('{ACT_ALLOC, 12'd4095, 12'd0, 1, ST_NO_SPACE, 12'd0});
		rows.push_back('{~ACT_ALLOC, 12'd0, 12'd4095, 1, ST_BAD_OFFSET, 12'd0});
		rows.push_back('{~ACT_ALLOC, 12'd0, 12'd25, 1, ST_BAD_OFFSET, 12'd0});
		rows.push_back('{ACT_ALLOC, 12'd100, 12'd0, 1, ST_OK, 12'd48});
		rows.push_back('{ACT_ALLOC, 12'd200, 12'd0, 0, ST_OK, 12'd0});
		rows.push_back('{ACT_ALLOC, 12'd300, 12'd0, 0, ST_OK, 12'd0});
		rows.push_back('{~ACT_ALLOC, 12'd0, 12'd48, 1, ST_OK, 12'd0});
		rows.push_back('{~ACT_ALLOC, 12'd0, 12'd48, 1, ST_OK, 12'd0});
		rows.push_back('{ACT_ALLOC, 12'd90, 12'd0, 0, ST_OK, 12'd0});
		rows.push_back('{~ACT_ALLOC, 12'd0, 12'd172, 0, ST_OK, 12'd0});
		rows.push_back('{~ACT_ALLOC, 12'd0, 12'd48, 0, ST_OK, 12'd0});
		rows.push_back('{~ACT_ALLOC, 12'd0, 12'd396, 0, ST_OK, 12'd0});
		rows.push_back('{ACT_ALLOC, 12'd3000, 12'd0, 0, ST_OK, 12'd0});
		rows.push_back('{ACT_ALLOC, 12'd2000, 12'd0, 0, ST_OK, 12'd0});
		rows.push_back('{~ACT_ALLOC, 12'd4095, 12'd24, 1, ST_OK, 12'd0});
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_item(rows[i].act, rows[i].req, rows[i].rel, rows[i].known,
				rows[i].status, rows[i].offset);
		for (int i = 0; i < N_RANDOM; i++) begin
			quiet_in = (i >= 600 && i < 800);
			quiet_out = quiet_in;
			pick = $urandom_range(99);
			req = (pick < 70) ? 12'($urandom_range(120)) : 12'($urandom);
			rel = 12'($urandom);
			if (live_offsets.size() > 0 && ($urandom_range(99) < 45 || live_offsets.size() > 40)) begin
				pick = $urandom_range(live_offsets.size() - 1);
				if ($urandom_range(99) < 90) begin
					rel = live_offsets[pick];
					live_offsets.delete(pick);
				end
				send_item(~ACT_ALLOC, 12'($urandom), rel, 0, ST_OK, 12'd0);
			end else if ($urandom_range(99) < 8) begin
				send_item(~ACT_ALLOC, req, rel, 0, ST_OK, 12'd0);
			end else begin
				send_item(ACT_ALLOC, req, rel, 0, ST_OK, 12'd0);
			end
		end
		s_tvalid <= 1'b0;
		drain = 0;
		while (pending_results.size() > 0 && drain < 100000) begin
			@(posedge clk);
			drain++;
		end
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("first_fit_block_allocator_unit_test passed");
		else
			$display("first_fit_block_allocator_unit_test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
design/ffa_pkg.sv
design/ffa_seg_ram.sv
design/ffa_ctrl.sv
design/first_fit_block_allocator_unit.sv
design/ffa_checker.sv
tb/sv/first_fit_block_allocator_unit_test.sv
